// ----- sv/field_map_trilinear_lookup_assert.svh -----
// assertion macros for the field map lookup
`ifndef FIELD_MAP_TRILINEAR_LOOKUP_ASSERT_SVH
`define FIELD_MAP_TRILINEAR_LOOKUP_ASSERT_SVH

// next-cycle implication, off while in reset
`define FMTL_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("fmtl check failed");

// what must hold in the cycle after reset
`define FMTL_CHK_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("fmtl reset check failed");

`endif

// ----- sv/fmtl_pkg.sv -----
`default_nettype none
package fmtl_pkg;

  localparam int ADDR_W = 18;
  localparam int STORE_DEPTH = 2 ** ADDR_W;
  localparam int DEF_NX = 64;
  localparam int DEF_NY = 32;
  localparam int DEF_NZ = 128;
  localparam int WT_W = 49;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_ORIGIN_Z,
    CFG_RECIP_X,
    CFG_RECIP_Y,
    CFG_RECIP_Z
  } cfg_idx_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [17:0]        load_addr;
    logic signed [15:0] load_bx;
    logic signed [15:0] load_by;
    logic signed [15:0] load_bz;
  } req_t;

  typedef struct packed {
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
    logic               inside_res;
  } res_t;

  // per-stage control that travels with each item
  typedef struct packed {
    logic              vld;
    logic              qry;
    logic              ins;
    logic [ADDR_W-1:0] addr;
    logic [47:0]       data;
  } ctl_t;

endpackage
`default_nettype wire

// ----- sv/field_map_trilinear_lookup.sv -----
// channel   dir  handshake        payload
// request   in   start, busy      req (fmtl_pkg::req_t)
// result    out  res_valid        res (fmtl_pkg::res_t)
// config    in   cfg_wr           cfg_idx, cfg_data
//
// one request per cycle; busy is high only during reset
// a query gives its result when it leaves the last stage; a load gives none
// nine stages: subtract, scale multiply, cell/fraction, two address and
// weight stages, replicated store read, weight multiply, two add stages
// sync reset clears valid bits and origins, sets each recip to 16777216; the store is not cleared
// result is a one-cycle strobe and cannot be stalled
`default_nettype none
`include "field_map_trilinear_lookup_assert.svh"
module field_map_trilinear_lookup #(
  parameter int GRID_NX = fmtl_pkg::DEF_NX,
  parameter int GRID_NY = fmtl_pkg::DEF_NY,
  parameter int GRID_NZ = fmtl_pkg::DEF_NZ
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire fmtl_pkg::req_t req,
  output logic               res_valid,
  output fmtl_pkg::res_t     res,
  input  wire logic          cfg_wr,
  input  wire logic [2:0]    cfg_idx,
  input  wire logic [31:0]   cfg_data
);

  localparam int CWX = $clog2(GRID_NX);
  localparam int CWY = $clog2(GRID_NY);
  localparam int CWZ = $clog2(GRID_NZ);
  localparam int AW = fmtl_pkg::ADDR_W;

  logic signed [31:0] origin_x, origin_y, origin_z;
  logic [31:0]        recip_x, recip_y, recip_z;

  fmtl_pkg::ctl_t c [1:9];

  logic [CWX-1:0] ix;
  logic [CWY-1:0] iy;
  logic [CWZ-1:0] iz;
  logic [15:0]    fx, fy, fz;
  logic           okx, oky, okz;

  logic [AW-1:0]             addr5 [8];
  logic [fmtl_pkg::WT_W-1:0] wt5 [8];
  logic [fmtl_pkg::WT_W-1:0] wt6 [8];
  logic [47:0]               rd6 [8];
  logic signed [15:0]        smp [3][8];
  logic signed [15:0]        comp [3];

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
      recip_x  <= 32'd16777216;
      recip_y  <= 32'd16777216;
      recip_z  <= 32'd16777216;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fmtl_pkg::CFG_ORIGIN_X: origin_x <= cfg_data;
        fmtl_pkg::CFG_ORIGIN_Y: origin_y <= cfg_data;
        fmtl_pkg::CFG_ORIGIN_Z: origin_z <= cfg_data;
        fmtl_pkg::CFG_RECIP_X:  recip_x  <= cfg_data;
        fmtl_pkg::CFG_RECIP_Y:  recip_y  <= cfg_data;
        fmtl_pkg::CFG_RECIP_Z:  recip_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  // control pipeline
  always_ff @(posedge clk) begin
    c[1].qry  <= req.req_type;
    c[1].ins  <= 1'b0;
    c[1].addr <= req.load_addr;
    c[1].data <= {req.load_bx, req.load_by, req.load_bz};
    for (int s = 2; s <= 9; s++) begin
      c[s].qry  <= c[s-1].qry;
      if (s != 4) begin
        c[s].ins <= c[s-1].ins;
      end
      c[s].addr <= c[s-1].addr;
      c[s].data <= c[s-1].data;
    end
    c[4].ins <= okx && oky && okz;
    if (rst) begin
      for (int s = 1; s <= 9; s++) begin
        c[s].vld <= 1'b0;
      end
    end else begin
      c[1].vld <= start && !busy;
      for (int s = 2; s <= 9; s++) begin
        c[s].vld <= c[s-1].vld;
      end
    end
  end

  fmtl_locate #(.N(GRID_NX), .CW(CWX)) u_loc_x (
    .clk(clk), .pos(req.pos_x), .org(origin_x), .rstep(recip_x),
    .idx(ix), .frac(fx), .ok(okx)
  );
  fmtl_locate #(.N(GRID_NY), .CW(CWY)) u_loc_y (
    .clk(clk), .pos(req.pos_y), .org(origin_y), .rstep(recip_y),
    .idx(iy), .frac(fy), .ok(oky)
  );
  fmtl_locate #(.N(GRID_NZ), .CW(CWZ)) u_loc_z (
    .clk(clk), .pos(req.pos_z), .org(origin_z), .rstep(recip_z),
    .idx(iz), .frac(fz), .ok(okz)
  );

  fmtl_corner #(
    .NX(GRID_NX), .NY(GRID_NY), .NZ(GRID_NZ), .CWX(CWX), .CWY(CWY), .CWZ(CWZ)
  ) u_corner (
    .ix(ix), .iy(iy), .iz(iz), .fx(fx), .fy(fy), .fz(fz), .clk(clk),
    .addr(addr5), .wt(wt5)
  );

  // one store copy per corner, every load writes all copies
  for (genvar k = 0; k < 8; k++) begin : g_bank
    fmtl_bank u_bank (
      .clk(clk),
      .we(c[5].vld && !c[5].qry),
      .waddr(c[5].addr),
      .wdata(c[5].data),
      .raddr(addr5[k]),
      .rdata(rd6[k])
    );
    always_comb begin
      smp[0][k] = rd6[k][47:32];
      smp[1][k] = rd6[k][31:16];
      smp[2][k] = rd6[k][15:0];
    end
  end

  always_ff @(posedge clk) begin
    wt6 <= wt5;
  end

  for (genvar m = 0; m < 3; m++) begin : g_blend
    fmtl_blend u_blend (
      .clk(clk), .smp(smp[m]), .wt(wt6), .res(comp[m])
    );
  end

  assign res_valid = c[9].vld && c[9].qry;
  always_comb begin
    res.inside_res = c[9].ins;
    res.field_x = c[9].ins ? comp[0] : '0;
    res.field_y = c[9].ins ? comp[1] : '0;
    res.field_z = c[9].ins ? comp[2] : '0;
  end

  `FMTL_CHK_NEXT(a_query_gives_result, start && !busy && req.req_type, ##8 res_valid)
  `FMTL_CHK_NEXT(a_no_spurious_result, !(start && !busy && req.req_type), ##8 !res_valid)
  `FMTL_CHK_RST(a_reset_clears_result, !res_valid)

endmodule
`default_nettype wire

// ----- sv/fmtl_locate.sv -----
`default_nettype none
module fmtl_locate #(
  parameter int N = fmtl_pkg::DEF_NX,
  parameter int CW = $clog2(N)
) (
  input  wire logic               clk,
  input  wire logic signed [31:0] pos,
  input  wire logic signed [31:0] org,
  input  wire logic [31:0]        rstep,
  output logic [CW-1:0]           idx,
  output logic [15:0]             frac,
  output logic                    ok
);

  logic signed [32:0] d1;
  logic               neg2;
  logic [63:0]        t2;

  always_ff @(posedge clk) begin
    d1   <= 33'(pos) - 33'(org);
    neg2 <= d1[32];
    t2   <= 64'(d1[31:0]) * 64'(rstep);
    ok   <= !neg2 && (t2[63:40] < 24'(N - 1));
    idx  <= t2[40 +: CW];
    frac <= t2[39:24];
  end

endmodule
`default_nettype wire

// ----- sv/fmtl_corner.sv -----
`default_nettype none
module fmtl_corner #(
  parameter int NX = fmtl_pkg::DEF_NX,
  parameter int NY = fmtl_pkg::DEF_NY,
  parameter int NZ = fmtl_pkg::DEF_NZ,
  parameter int CWX = $clog2(NX),
  parameter int CWY = $clog2(NY),
  parameter int CWZ = $clog2(NZ)
) (
  input  wire logic [CWX-1:0] ix,
  input  wire logic [CWY-1:0] iy,
  input  wire logic [CWZ-1:0] iz,
  input  wire logic [15:0]    fx,
  input  wire logic [15:0]    fy,
  input  wire logic [15:0]    fz,
  input  wire logic           clk,
  output logic [fmtl_pkg::ADDR_W-1:0] addr [8],
  output logic [fmtl_pkg::WT_W-1:0]   wt [8]
);

  localparam int AW = fmtl_pkg::ADDR_W;

  logic [AW-1:0] rxy [4];
  logic [32:0]   wxy [4];
  logic [AW-1:0] iz4;
  logic [16:0]   wz4 [2];
  logic [16:0]   wx [2];
  logic [16:0]   wy [2];
  logic [AW-1:0] ixa [2];

  always_comb begin
    wx[0] = 17'h10000 - 17'(fx);
    wx[1] = 17'(fx);
    wy[0] = 17'h10000 - 17'(fy);
    wy[1] = 17'(fy);
    ixa[0] = AW'(ix);
    ixa[1] = AW'(ix) + AW'(1);
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      rxy[j] <= AW'(ixa[j & 1] * AW'(NY)) + AW'(iy) + AW'(j >> 1);
      wxy[j] <= 33'(wx[j & 1]) * 33'(wy[j >> 1]);
    end
    iz4    <= AW'(iz);
    wz4[0] <= 17'h10000 - 17'(fz);
    wz4[1] <= 17'(fz);
    for (int k = 0; k < 8; k++) begin
      addr[k] <= AW'(rxy[k & 3] * AW'(NZ)) + iz4 + AW'(k >> 2);
      wt[k]   <= fmtl_pkg::WT_W'(wxy[k & 3]) * fmtl_pkg::WT_W'(wz4[k >> 2]);
    end
  end

endmodule
`default_nettype wire

// ----- sv/fmtl_bank.sv -----
`default_nettype none
module fmtl_bank (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [fmtl_pkg::ADDR_W-1:0] waddr,
  input  wire logic [47:0]                 wdata,
  input  wire logic [fmtl_pkg::ADDR_W-1:0] raddr,
  output logic [47:0]                      rdata
);

  logic [47:0] mem [fmtl_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/fmtl_blend.sv -----
`default_nettype none
module fmtl_blend (
  input  wire logic                      clk,
  input  wire logic signed [15:0]        smp [8],
  input  wire logic [fmtl_pkg::WT_W-1:0] wt [8],
  output logic signed [15:0]             res
);

  logic signed [65:0] prod [8];
  logic signed [66:0] pair [4];
  logic signed [68:0] total;
  logic signed [20:0] q;

  always_comb begin
    total = 69'(pair[0]) + 69'(pair[1]) + 69'(pair[2]) + 69'(pair[3])
          + 69'(64'h0000_8000_0000_0000);
    q = 21'(total >>> 48);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      prod[k] <= 66'(smp[k]) * 66'($signed({1'b0, wt[k]}));
    end
    for (int j = 0; j < 4; j++) begin
      pair[j] <= 67'(prod[2 * j]) + 67'(prod[2 * j + 1]);
    end
    if (q > 21'sd32767) begin
      res <= 16'sh7fff;
    end else if (q < -21'sd32768) begin
      res <= -16'sh8000;
    end else begin
      res <= 16'(q);
    end
  end

endmodule
`default_nettype wire
